// File: rtl/tse_pkg.sv
// Shared types and constants of the trigonometric series evaluator.
// Holds channel payload structs, fixed-point constants and the Horner tables.
// No dependencies.
package tse_pkg;

  localparam int COEFF_DEPTH_DEF = 64;
  localparam int CFG_W           = 7;
  localparam int IDX_W           = 6;
  localparam int COEF_W          = 32;
  localparam int ACC_W           = 48;
  localparam int HORNER_N        = 6;

  localparam logic [CFG_W-1:0] COUNT_RESET = 7'd64;
  localparam logic [32:0]      ONE_Q30     = 33'h0_4000_0000;
  localparam logic [32:0]      PI_Q30      = 33'd3373259426;
  localparam logic signed [55:0] ACC_MAX   = 56'sh00_7FFF_FFFF_FFFF;
  localparam logic signed [55:0] ACC_MIN   = -56'sh00_8000_0000_0000;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_EVAL = 1'b1
  } func_t;

  typedef struct packed {
    logic                     func;
    logic [IDX_W-1:0]         coeff_index;
    logic signed [COEF_W-1:0] coeff_value;
    logic [31:0]              angle;
  } req_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] cos_sum;
    logic signed [ACC_W-1:0] sin_sum;
    logic                    saturated;
  } rsp_t;

  typedef logic [CFG_W-1:0] cfg_t;

  // Divisors of the Taylor series Horner steps, highest order first.
  function automatic logic [7:0] horner_k(input logic [2:0] j);
    case (j)
      3'd0:    return 8'd156;
      3'd1:    return 8'd110;
      3'd2:    return 8'd72;
      3'd3:    return 8'd42;
      3'd4:    return 8'd20;
      default: return 8'd6;
    endcase
  endfunction

  // Reciprocals floor(2^32 / k) of the divisors above.
  function automatic logic [29:0] horner_m(input logic [2:0] j);
    case (j)
      3'd0:    return 30'd27531841;
      3'd1:    return 30'd39045157;
      3'd2:    return 30'd59652323;
      3'd3:    return 30'd102261126;
      3'd4:    return 30'd214748364;
      default: return 30'd715827882;
    endcase
  endfunction

endpackage

// File: rtl/tse_chan_if.sv
// Valid/ready channel interface used for requests, results and configuration.
// The payload type is a parameter; no other dependencies.
interface tse_chan_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/trig_series_evaluator.sv
// Trigonometric series evaluator: coefficient memory plus a multi-cycle sequencer.
// Depends on tse_pkg and tse_chan_if.
// A load transaction writes one memory entry. An evaluate transaction runs two sine
// evaluations (S_T, S_T2, the Horner steps, S_V) on the shared 33x33 multiplier,
// then the steps S_LU, S_MH and S_ML per coefficient for the split 48x33 product.
// One evaluation runs at a time. Reset is synchronous; the coefficient memory is
// not cleared and an entry holds garbage until it is loaded.
module trig_series_evaluator #(
  parameter int COEFF_DEPTH = tse_pkg::COEFF_DEPTH_DEF
) (
  input logic       clk,
  input logic       rst,
  tse_chan_if.sink   req,
  tse_chan_if.source rsp,
  tse_chan_if.sink   cfg
);
  import tse_pkg::*;

  localparam int AW = (COEFF_DEPTH > 1) ? $clog2(COEFF_DEPTH) : 1;
  localparam int CW = $clog2(COEFF_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_T, S_T2, S_HX, S_HQ, S_HC, S_V, S_LAM, S_LU, S_MH, S_ML
  } state_t;

  typedef enum logic [1:0] {
    MP_LOOP, MP_COS, MP_SIN
  } mphase_t;

  // Clip to the signed 48-bit range; the top bit flags a clip.
  function automatic logic [48:0] clip48(input logic signed [55:0] v);
    if (v > ACC_MAX) return {1'b1, ACC_MAX[47:0]};
    if (v < ACC_MIN) return {1'b1, ACC_MIN[47:0]};
    return {1'b0, v[47:0]};
  endfunction

  state_t  state;
  mphase_t mphase;
  logic [CFG_W-1:0] coeff_count;
  logic [31:0] angle_r;
  logic        diff;
  logic        trig_sel;
  logic [2:0]  k_idx;
  logic [CW-1:0] i;
  logic        sat;
  logic [31:0] t, t2, x, q0, s;
  logic signed [31:0] c, sv;
  logic signed [33:0] lam;
  logic signed [47:0] u, d, s1;
  logic [56:0] ph;
  logic        out_valid;
  rsp_t        out_q;

  logic signed [COEF_W-1:0] mem [COEFF_DEPTH];
  logic signed [COEF_W-1:0] rdata;

  // Request channel decode and coefficient count clamp.
  logic          acc_req;
  logic [CW-1:0] n_use;
  logic          idx_ok;
  logic [CW-1:0] i_dec;
  assign acc_req = req.valid && req.ready;
  assign n_use   = (32'(coeff_count) > COEFF_DEPTH) ? CW'(COEFF_DEPTH) : CW'(coeff_count);
  assign idx_ok  = 32'(req.data.coeff_index) < COEFF_DEPTH;
  assign i_dec   = i - CW'(1);

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_q;

  // The result register is loaded in the last step of an evaluation.
  logic rsp_load;
  assign rsp_load = (state == S_ML) && (mphase != MP_LOOP) && (mphase != MP_COS) &&
                    (!out_valid || rsp.ready);

  // Folded phase for the sine unit.
  logic [32:0] w;
  logic [31:0] rr;
  logic        sneg;
  always_comb begin
    if (trig_sel) begin
      w = {angle_r, 1'b0};
    end else if (diff) begin
      w = {1'b0, angle_r} + 33'h0_8000_0000;
    end else begin
      w = {1'b0, angle_r};
    end
    sneg = w[32];
    rr   = (w[31:0] > 32'h8000_0000) ? 32'(33'h1_0000_0000 - 33'(w[31:0])) : w[31:0];
  end

  // Magnitudes for the split product.
  logic [47:0] umag;
  logic [32:0] lammag, bmag;
  logic [30:0] cmag, svmag;
  logic        mneg;
  always_comb begin
    umag   = u[47] ? 48'(-u) : 48'(u);
    lammag = lam[33] ? 33'(-lam) : 33'(lam);
    cmag   = c[31] ? 31'(-c) : 31'(c);
    svmag  = sv[31] ? 31'(-sv) : 31'(sv);
    bmag   = (mphase == MP_SIN) ? 33'(svmag) : lammag;
    mneg   = u[47] ^ ((mphase == MP_SIN) ? sv[31] : lam[33]);
  end

  // Shared multiplier operand selection.
  logic [32:0] mul_a, mul_b;
  logic [65:0] prod;
  always_comb begin
    case (state)
      S_T:     begin mul_a = 33'(rr);          mul_b = PI_Q30;               end
      S_T2:    begin mul_a = 33'(t);           mul_b = 33'(t);               end
      S_HX:    begin mul_a = 33'(t2);          mul_b = 33'(s);               end
      S_HQ:    begin mul_a = 33'(x);           mul_b = 33'(horner_m(k_idx)); end
      S_V:     begin mul_a = 33'(t);           mul_b = 33'(s);               end
      S_LAM:   begin mul_a = 33'(cmag);        mul_b = 33'(cmag);            end
      S_MH:    begin mul_a = 33'(umag[47:24]); mul_b = bmag;                 end
      S_ML:    begin mul_a = 33'(umag[23:0]);  mul_b = bmag;                 end
      default: begin mul_a = '0;               mul_b = '0;                   end
    endcase
  end
  assign prod = 66'(mul_a) * 66'(mul_b);

  // Horner step: correct the reciprocal quotient by at most one.
  logic [39:0] rem;
  logic [31:0] q;
  assign rem = 40'(x) - 40'(q0) * 40'(horner_k(k_idx));
  assign q   = (rem >= 40'(horner_k(k_idx))) ? q0 + 32'd1 : q0;

  // Sine value clipped to one, with its sign.
  logic [35:0] vraw;
  logic [31:0] vclip;
  assign vraw  = prod[65:30];
  assign vclip = (vraw > 36'(ONE_Q30)) ? 32'(ONE_Q30) : vraw[31:0];

  // Combine the two partial products of u times lambda or sine.
  logic [57:0] msum;
  logic signed [55:0] mterm;
  logic [57:0] mshift;
  assign msum   = 58'(ph) + 58'(prod[65:24]);
  assign mshift = (mphase == MP_COS) ? (msum >> 7) : (msum >> 6);
  assign mterm  = mneg ? -56'(mshift) : 56'(mshift);

  // Recurrence updates.
  logic [48:0] u_clip, d_clip, s1_clip, s2_clip;
  always_comb begin
    u_clip  = clip48(diff ? (56'(d) - 56'(u)) : (56'(d) + 56'(u)));
    d_clip  = clip48(diff ? (mterm - 56'(d) + 56'(rdata)) : (mterm + 56'(d) + 56'(rdata)));
    s1_clip = clip48(56'(d) - mterm);
    s2_clip = clip48(mterm);
  end

  // Coefficient memory: written by load transactions, read once per iteration.
  always_ff @(posedge clk) begin
    if (acc_req && req.data.func == FUNC_LOAD && idx_ok) begin
      mem[AW'(req.data.coeff_index)] <= req.data.coeff_value;
    end
    if (state == S_LU) begin
      rdata <= mem[i_dec[AW-1:0]];
    end
  end

  // Sequencer, datapath registers and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      mphase      <= MP_LOOP;
      coeff_count <= COUNT_RESET;
      out_valid   <= 1'b0;
      trig_sel    <= 1'b0;
      k_idx       <= '0;
      i           <= '0;
      sat         <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        coeff_count <= cfg.data;
      end
      if (out_valid && rsp.ready && !rsp_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (acc_req && req.data.func == FUNC_EVAL) begin
            angle_r  <= req.data.angle;
            diff     <= (req.data.angle >= 32'h4000_0000) &&
                        (req.data.angle <= 32'hC000_0000);
            sat      <= 1'b0;
            i        <= n_use;
            u        <= '0;
            d        <= '0;
            trig_sel <= 1'b0;
            mphase   <= MP_LOOP;
            state    <= S_T;
          end
        end
        S_T: begin
          t     <= 32'((prod + 66'h8000_0000) >> 32);
          state <= S_T2;
        end
        S_T2: begin
          t2    <= 32'((prod + 66'h2000_0000) >> 30);
          s     <= 32'(ONE_Q30);
          k_idx <= '0;
          state <= S_HX;
        end
        S_HX: begin
          x     <= prod[61:30];
          state <= S_HQ;
        end
        S_HQ: begin
          q0    <= prod[63:32];
          state <= S_HC;
        end
        S_HC: begin
          s <= 32'(ONE_Q30) - q;
          if (k_idx == 3'(HORNER_N - 1)) begin
            state <= S_V;
          end else begin
            k_idx <= k_idx + 3'd1;
            state <= S_HX;
          end
        end
        S_V: begin
          if (!trig_sel) begin
            c     <= sneg ? -$signed(vclip) : $signed(vclip);
            state <= S_LAM;
          end else begin
            sv     <= sneg ? -$signed(vclip) : $signed(vclip);
            mphase <= MP_LOOP;
            state  <= S_LU;
          end
        end
        S_LAM: begin
          lam      <= diff ? $signed(34'(prod[60:28])) : -$signed(34'(prod[60:28]));
          trig_sel <= 1'b1;
          state    <= S_T;
        end
        S_LU: begin
          if (i == '0) begin
            mphase <= MP_COS;
          end else begin
            u   <= u_clip[47:0];
            sat <= sat | u_clip[48];
          end
          state <= S_MH;
        end
        S_MH: begin
          ph    <= prod[56:0];
          state <= S_ML;
        end
        S_ML: begin
          case (mphase)
            MP_LOOP: begin
              d     <= d_clip[47:0];
              sat   <= sat | d_clip[48];
              i     <= i - CW'(1);
              state <= S_LU;
            end
            MP_COS: begin
              s1     <= s1_clip[47:0];
              sat    <= sat | s1_clip[48];
              mphase <= MP_SIN;
              state  <= S_MH;
            end
            default: begin
              // Hold here until the result register is free.
              if (rsp_load) begin
                out_q.cos_sum   <= s1;
                out_q.sin_sum   <= s2_clip[47:0];
                out_q.saturated <= sat | s2_clip[48];
                out_valid       <= 1'b1;
                state           <= S_IDLE;
              end
            end
          endcase
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: dv/tse_sum_checker.sv
// Checker of the trigonometric series evaluator: watches the three channels,
// predicts each evaluate result in fixed point and compares it field by field.
// Depends on tse_pkg for the payload types.
`timescale 1ns / 100ps

module tse_sum_checker
  import tse_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  input  logic  req_ready,
  input  req_t  req_data,
  input  logic  rsp_valid,
  input  logic  rsp_ready,
  input  rsp_t  rsp_data,
  input  logic  cfg_valid,
  input  logic  cfg_ready,
  input  cfg_t  cfg_data,
  output int    fail_count,
  output int    pending
);

  localparam int TABLE_DEPTH = 64;
  localparam logic [63:0] Q30_ONE = 64'h4000_0000;
  localparam longint SUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_MIN = -SUM_MAX - 1;
  localparam int unsigned TAYLOR_DIV [6] = '{156, 110, 72, 42, 20, 6};

  longint coeff_table [TABLE_DEPTH];
  cfg_t   active_count;
  logic   clip_seen;
  rsp_t   sums_due [$];

  // Sine of 2*pi*w/2^33 in Q2.30, w taken modulo 2^33.
  function automatic longint sine_q30(input logic [63:0] w);
    logic [63:0] r, t, t2, s, v;
    logic neg;
    neg = w[32];
    r = {32'b0, w[31:0]};
    if (r > 64'h8000_0000) r = 64'h1_0000_0000 - r;
    t = (r * 64'd3373259426 + 64'h8000_0000) >> 32;
    t2 = (t * t + (64'd1 << 29)) >> 30;
    s = Q30_ONE;
    for (int k = 0; k < 6; k++) s = Q30_ONE - ((t2 * s) >> 30) / TAYLOR_DIV[k];
    v = (t * s) >> 30;
    if (v > Q30_ONE) v = Q30_ONE;
    return neg ? -longint'(v) : longint'(v);
  endfunction

  // Product shifted right by sh, truncated toward zero.
  function automatic longint scaled_product(input longint a, input longint b,
                                            input int sh);
    logic [63:0] ma, mb, hi, lo, m;
    ma = a < 0 ? 64'(-a) : 64'(a);
    mb = b < 0 ? 64'(-b) : 64'(b);
    hi = (ma >> 24) * mb;
    lo = (ma & 64'hFF_FFFF) * mb;
    m = (hi + (lo >> 24)) >> (sh - 24);
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  // Clamp to the signed 48-bit accumulator range and note any clipping.
  function automatic longint clamp_sum(input longint v);
    if (v > SUM_MAX) begin
      clip_seen = 1'b1;
      return SUM_MAX;
    end
    if (v < SUM_MIN) begin
      clip_seen = 1'b1;
      return SUM_MIN;
    end
    return v;
  endfunction

  // Reinsch recurrence over the active coefficients at one angle.
  function automatic rsp_t series_sums(input logic [31:0] a);
    longint lam, u, d, c, coef, s1, s2;
    int n;
    logic diff;
    rsp_t res;
    clip_seen = 1'b0;
    u = 0;
    d = 0;
    n = (active_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(active_count);
    diff = (a >= 32'h4000_0000) && (a <= 32'hC000_0000);
    if (diff) begin
      c = sine_q30({32'b0, a} + 64'h8000_0000);
      lam = longint'(64'(c * c) >> 28);
    end else begin
      c = sine_q30({32'b0, a});
      lam = -longint'(64'(c * c) >> 28);
    end
    for (int i = n; i > 0; i--) begin
      coef = coeff_table[(i - 1) % TABLE_DEPTH];
      if (diff) begin
        u = clamp_sum(d - u);
        d = clamp_sum(scaled_product(u, lam, 30) - d + coef);
      end else begin
        u = clamp_sum(d + u);
        d = clamp_sum(scaled_product(u, lam, 30) + d + coef);
      end
    end
    s1 = clamp_sum(d - scaled_product(u, lam, 31));
    s2 = clamp_sum(scaled_product(u, sine_q30({31'b0, a, 1'b0}), 30));
    res.cos_sum = s1[47:0];
    res.sin_sum = s2[47:0];
    res.saturated = clip_seen;
    return res;
  endfunction

  assign pending = sums_due.size();

  // Track configuration and loads, queue predictions and check results.
  always @(posedge clk) begin
    rsp_t want;
    int   errs;
    errs = 0;
    if (rst) begin
      active_count <= COUNT_RESET;
      sums_due.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) active_count <= cfg_data;
      if (rsp_valid && rsp_ready) begin
        if (sums_due.size() == 0) begin
          $error("result transaction with no evaluation outstanding");
          errs++;
        end else begin
          want = sums_due.pop_front();
          if (rsp_data.cos_sum !== want.cos_sum) begin
            $error("cos_sum: expected %0d, got %0d", want.cos_sum, rsp_data.cos_sum);
            errs++;
          end
          if (rsp_data.sin_sum !== want.sin_sum) begin
            $error("sin_sum: expected %0d, got %0d", want.sin_sum, rsp_data.sin_sum);
            errs++;
          end
          if (rsp_data.saturated !== want.saturated) begin
            $error("saturated: expected %0b, got %0b", want.saturated,
                   rsp_data.saturated);
            errs++;
          end
        end
      end
      if (req_valid && req_ready) begin
        if (req_data.func == FUNC_LOAD)
          coeff_table[req_data.coeff_index] = longint'(req_data.coeff_value);
        else
          sums_due.push_back(series_sums(req_data.angle));
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

// File: dv/trig_series_evaluator_test.sv
// Top of the trigonometric series evaluator testbench: clock, reset, stimulus,
// result back-pressure and the verdict. Depends on tse_pkg, tse_chan_if,
// trig_series_evaluator and tse_sum_checker.
`timescale 1ns / 100ps

module trig_series_evaluator_test;
  import tse_pkg::*;

  localparam int STALL_LIMIT = 6000;
  localparam int DRAIN_CYCLES = 300;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   stall_cycles;
  logic calm;
  logic [63:0] loaded;

  tse_chan_if #(.T(req_t)) req_ch ();
  tse_chan_if #(.T(rsp_t)) rsp_ch ();
  tse_chan_if #(.T(cfg_t)) cfg_ch ();

  trig_series_evaluator i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  tse_sum_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_ch.valid),
    .req_ready  (req_ch.ready),
    .req_data   (req_ch.data),
    .rsp_valid  (rsp_ch.valid),
    .rsp_ready  (rsp_ch.ready),
    .rsp_data   (rsp_ch.data),
    .cfg_valid  (cfg_ch.valid),
    .cfg_ready  (cfg_ch.ready),
    .cfg_data   (cfg_ch.data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Watchdog on cycles with no transaction on any channel.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Result side: random stalls, and one long hold-off to back up the block.
  initial begin
    int taken;
    int hold;
    taken = 0;
    hold = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready) taken++;
      if (taken == 20 && hold == 0) hold = 700;
      if (hold > 1) begin
        rsp_ch.ready <= 1'b0;
        hold--;
      end else begin
        rsp_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 20);
      end
    end
  end

  function automatic logic [31:0] pick_coeff();
    case ($urandom_range(9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom();
      default: return 32'($signed($urandom_range(32'h0100_0000))) - 32'h0080_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_angle();
    case ($urandom_range(9))
      0: return 32'h4000_0000 + $urandom_range(4) - 2;
      1: return 32'hC000_0000 + $urandom_range(4) - 2;
      2: return $urandom_range(3) - 1;
      default: return $urandom();
    endcase
  endfunction

  // Offer one request transaction, with an optional gap before it.
  task automatic send_request(input req_t item);
    if (!calm && $urandom_range(99) < 20) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= item;
    do @(posedge clk); while (!req_ch.ready);
    if (item.func == FUNC_LOAD) loaded[item.coeff_index] = 1'b1;
  endtask

  task automatic load_coeff(input int idx, input logic [31:0] value);
    req_t item;
    item.func = FUNC_LOAD;
    item.coeff_index = idx[5:0];
    item.coeff_value = value;
    item.angle = $urandom();
    send_request(item);
  endtask

  task automatic evaluate_at(input logic [31:0] a);
    req_t item;
    item.func = FUNC_EVAL;
    item.coeff_index = $urandom();
    item.coeff_value = $urandom();
    item.angle = a;
    send_request(item);
  endtask

  // Wait for all results, let the block settle, then write the count.
  task automatic set_count(input cfg_t value);
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // Random phase; an evaluation only once every entry it reads is loaded.
  task automatic run_phase(input cfg_t count, input int items);
    int used;
    int gap;
    set_count(count);
    used = (count > 64) ? 64 : int'(count);
    for (int k = 0; k < items; k++) begin
      gap = -1;
      for (int j = 0; j < used; j++) if (!loaded[j] && gap < 0) gap = j;
      if (gap >= 0) load_coeff(gap, pick_coeff());
      else if ($urandom_range(99) < 40) load_coeff($urandom_range(63), pick_coeff());
      else evaluate_at(pick_angle());
    end
  endtask

  // Stimulus and verdict.
  initial begin
    cfg_t counts [10];
    counts = '{7'd0, 7'd1, 7'd64, 7'd127, 7'd2, 7'd33, 7'd5, 7'd100, 7'd12, 7'd3};
    calm = 1'b0;
    loaded = '0;
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.data <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: extreme coefficients and the angles at the region borders.
    set_count(7'd4);
    load_coeff(0, 32'h7FFF_FFFF);
    load_coeff(1, 32'h8000_0000);
    load_coeff(2, 32'h0000_0000);
    load_coeff(3, 32'hFFFF_FFFF);
    load_coeff(63, 32'h0080_0000);
    foreach (counts[i]) begin end
    evaluate_at(32'h0000_0000);
    evaluate_at(32'hFFFF_FFFF);
    evaluate_at(32'h3FFF_FFFF);
    evaluate_at(32'h4000_0000);
    evaluate_at(32'h8000_0000);
    evaluate_at(32'hC000_0000);
    evaluate_at(32'hC000_0001);
    evaluate_at(32'h2000_0000);
    evaluate_at(32'hA5A5_A5A5);
    evaluate_at(32'h5A5A_5A5A);
    load_coeff(2, 32'h5555_5555);
    load_coeff(3, 32'hAAAA_AAAA);
    evaluate_at(32'h1234_5678);

    // Random phases over a spread of counts; one phase runs without gaps.
    foreach (counts[i]) begin
      calm = (i == 4);
      run_phase(counts[i], 133);
    end
    calm = 1'b0;

    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
